>>> hw/rtl/kscm_pkg.sv
package kscm_pkg;

  localparam logic [31:0] MASK_FIRST    = 32'h11111111;
  localparam logic [31:0] MASK_UNPADDED = 32'h22222222;
  localparam logic [31:0] MASK_PADDED   = 32'h44444444;
  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam int          KEY_WORDS     = 4;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [7:0][31:0]  chain_t;
  typedef logic [KEY_WORDS-1:0][63:0] key_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

>>> hw/rtl/kscm_ifs.sv
interface kscm_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  byte_count;
  logic        last_item;
  modport source (output valid, message_word, byte_count, last_item, input ready);
  modport sink (input valid, message_word, byte_count, last_item, output ready);
endinterface

interface kscm_tag_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_word_0;
  logic [63:0] tag_word_1;
  logic [63:0] tag_word_2;
  logic [63:0] tag_word_3;
  modport source (output valid, tag_word_0, tag_word_1, tag_word_2, tag_word_3, input ready);
  modport sink (input valid, tag_word_0, tag_word_1, tag_word_2, tag_word_3, output ready);
endinterface

>>> hw/rtl/kscm_regs.sv
module kscm_regs import kscm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output key_t        key
);

  assign pready = 1'b1;
  assign prdata = key[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (psel && penable && pwrite) begin
      key[paddr[4:3]] <= pwdata;
    end
  end

endmodule

>>> hw/rtl/kscm_core.sv
module kscm_core import kscm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  blk_t       block,
  input  chain_t     init,
  output chain_t     vars,
  output core_stat_t stat
);

  blk_t       w;
  logic [5:0] round;
  logic [31:0] t1, t2, w_new;

  // w[0] always holds the current schedule word; the window slides by one per round
  always_comb begin
    w_new = sml_sig1(w[14]) + w[9] + sml_sig0(w[1]) + w[0];
    t1 = vars[7] + big_sig1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
         + round_k(round) + w[0];
    t2 = big_sig0(vars[0]) + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      round <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        round     <= '0;
      end else if (stat.busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w    <= block;
      vars <= init;
    end else if (stat.busy) begin
      w    <= {w_new, w[15:1]};
      vars <= {vars[6:4], vars[3] + t1, vars[2:0], t1 + t2};
    end
  end

endmodule

>>> hw/rtl/keyed_sha256_chain_mac_unit.sv
// Keyed MAC over the SHA-256 compression function. Message bytes are taken one
// per cycle from each accepted beat, except while a full block is compressed, and every
// block that proves not to be the last is compressed in the single round unit,
// which runs one round per cycle. A beat with last_item set then takes one or two
// further compressions before the tag beat is offered, longer
// if the previous tag beat has not yet been taken; the input is not ready while
// a beat is being worked on. The key registers are read at the first compression
// of each message.
module keyed_sha256_chain_mac_unit import kscm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  kscm_msg_if.sink    msg,
  kscm_tag_if.source  tag,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_BYTE = 8'b00000010,
    S_FIN  = 8'b00000100,
    S_PADZ = 8'b00001000,
    S_CLR  = 8'b00010000,
    S_ABS  = 8'b00100000,
    S_WAIT = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t     state, ret;
  key_t       key;
  chain_t     chain, vars, key_chain;
  blk_t       buffer;
  core_stat_t core_stat;
  logic [63:0] word;
  logic [3:0]  cnt, idx;
  logic        last;
  logic [6:0]  fill;
  logic [1:0]  bdone;
  logic [7:0]  cur_byte;
  logic        tag_valid;
  logic [3:0][63:0] tag_data;

  function automatic blk_t pad_from(input blk_t b, input logic [6:0] pos);
    blk_t r;
    r = b;
    for (int j = 0; j < 64; j++) begin
      if (7'(j) == pos) r[j / 4][8 * (3 - j % 4) +: 8] = PAD_BYTE;
      else if (7'(j) > pos) r[j / 4][8 * (3 - j % 4) +: 8] = 8'h00;
    end
    return r;
  endfunction

  kscm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .key
  );

  kscm_core u_core (
    .clk, .rst,
    .start (state == S_ABS),
    .block (buffer),
    .init  ((bdone == 2'd0) ? key_chain : chain),
    .vars,
    .stat  (core_stat)
  );

  always_comb begin
    for (int k = 0; k < KEY_WORDS; k++) begin
      key_chain[2 * k]     = key[k][63:32];
      key_chain[2 * k + 1] = key[k][31:0];
    end
  end

  assign cur_byte       = 8'(word >> (7'd56 - {1'b0, idx[2:0], 3'b000}));
  assign msg.ready      = (state == S_IDLE);
  assign tag.valid      = tag_valid;
  assign tag.tag_word_0 = tag_data[0];
  assign tag.tag_word_1 = tag_data[1];
  assign tag.tag_word_2 = tag_data[2];
  assign tag.tag_word_3 = tag_data[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      fill      <= '0;
      bdone     <= '0;
      tag_valid <= 1'b0;
    end else begin
      // S_OUT handles the tag register itself
      if (tag_valid && tag.ready && state != S_OUT) tag_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (msg.valid) begin
            word  <= msg.message_word;
            cnt   <= (msg.byte_count > 4'd8) ? 4'd8 : msg.byte_count;
            last  <= msg.last_item;
            idx   <= '0;
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (idx == cnt) begin
            state <= last ? S_FIN : S_IDLE;
          end else if (fill == 7'd64) begin
            // full block and more bytes follow: compress, then place this byte
            fill  <= '0;
            ret   <= S_BYTE;
            state <= S_ABS;
          end else begin
            buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= cur_byte;
            fill <= fill + 7'd1;
            idx  <= idx + 4'd1;
          end
        end
        S_FIN: begin
          state <= S_ABS;
          if (fill == 7'd64) begin
            if (bdone != 2'd0) begin
              for (int k = 0; k < 8; k++) chain[k] <= chain[k] ^ MASK_UNPADDED;
              ret <= S_OUT;
            end else begin
              ret <= S_PADZ;
            end
          end else begin
            buffer <= pad_from(buffer, fill);
            if (bdone == 2'd0) begin
              ret <= S_CLR;
            end else begin
              for (int k = 0; k < 8; k++) chain[k] <= chain[k] ^ MASK_PADDED;
              ret <= S_OUT;
            end
          end
        end
        S_PADZ: begin
          buffer <= pad_from(buffer, 7'd0);
          for (int k = 0; k < 8; k++) chain[k] <= chain[k] ^ MASK_PADDED;
          ret   <= S_OUT;
          state <= S_ABS;
        end
        S_CLR: begin
          // single-block message gets an all-zero second block
          buffer <= '0;
          for (int k = 0; k < 8; k++) chain[k] <= chain[k] ^ MASK_PADDED;
          ret   <= S_OUT;
          state <= S_ABS;
        end
        S_ABS: begin
          if (bdone == 2'd0) chain <= key_chain;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (core_stat.done) begin
            for (int k = 0; k < 8; k++)
              chain[k] <= (chain[k] + vars[k]) ^ ((bdone == 2'd0) ? MASK_FIRST : 32'h0);
            if (bdone != 2'd2) bdone <= bdone + 2'd1;
            state <= ret;
          end
        end
        S_OUT: begin
          if (!tag_valid || tag.ready) begin
            for (int k = 0; k < 4; k++) tag_data[k] <= {chain[2 * k], chain[2 * k + 1]};
            tag_valid <= 1'b1;
            fill      <= '0;
            bdone     <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> state == S_WAIT) else $error("compression finished outside wait");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= 7'd64) else $error("block fill beyond 64 bytes");
  a_bdone_sat: assert property (@(posedge clk) disable iff (rst)
    bdone != 2'd3) else $error("block counter past saturation");
  a_tag_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!tag_valid || tag.ready)) |=> (fill == 7'd0 && tag_valid))
    else $error("tag load did not reset message state");
`endif

endmodule

>>> tb/sv/keyed_sha256_chain_mac_unit_tb.sv
`timescale 1ns / 1ps

module keyed_sha256_chain_mac_unit_tb import kscm_pkg::*;;

  typedef enum int {REG_KEY_0 = 0, REG_KEY_1 = 1, REG_KEY_2 = 2, REG_KEY_3 = 3} reg_idx_t;

  localparam int TARGET_BEATS = 1750;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
  } tag_exp_t;

  class tag_scoreboard;
    logic [63:0] key_reg[KEY_WORDS];
    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    int          fill;
    int          nblocks;
    tag_exp_t    tags_due[$];
    int          errors;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      foreach (chain[i]) chain[i] = '0;
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
      nblocks = 0;
      errors = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] rk(int i);
      logic [31:0] k[64];
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
    endfunction

    function void compress();
      logic [31:0] w[16];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1, a, e;
      int r;
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      foreach (v[i]) v[i] = chain[i];
      for (int n = 0; n < 64; n++) begin
        r = n % 16;
        if (n >= 16) begin
          a = w[(r + 1) % 16];
          e = w[(r + 14) % 16];
          s0 = ror(a, 7) ^ ror(a, 18) ^ (a >> 3);
          s1 = ror(e, 17) ^ ror(e, 19) ^ (e >> 10);
          w[r] = w[r] + s0 + w[(r + 9) % 16] + s1;
        end
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk(n) + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] += v[i];
    endfunction

    function void mask_chain(logic [31:0] m);
      foreach (chain[i]) chain[i] ^= m;
    endfunction

    // first block of a message picks the key up
    function void take_block();
      if (nblocks == 0)
        for (int i = 0; i < 4; i++) begin
          chain[2*i] = key_reg[i][63:32];
          chain[2*i+1] = key_reg[i][31:0];
        end
      compress();
      if (nblocks == 0) mask_chain(MASK_FIRST);
      if (nblocks < 2) nblocks++;
    endfunction

    function void pad_at(int pos);
      blk[pos] = PAD_BYTE;
      for (int p = pos + 1; p < 64; p++) blk[p] = 8'h00;
    endfunction

    function void note_beat(logic [63:0] word, logic [3:0] cnt, logic last);
      int c;
      tag_exp_t t;
      c = (cnt > 8) ? 8 : cnt;
      for (int i = 0; i < c; i++) begin
        if (fill >= 64) begin
          take_block();
          fill = 0;
        end
        blk[fill] = word[63-8*i -: 8];
        fill++;
      end
      if (!last) return;
      if (fill >= 64) begin
        if (nblocks >= 1) begin
          mask_chain(MASK_UNPADDED);
          take_block();
        end else begin
          take_block();
          pad_at(0);
          mask_chain(MASK_PADDED);
          take_block();
        end
      end else begin
        pad_at(fill);
        if (nblocks == 0) begin
          take_block();
          foreach (blk[i]) blk[i] = 8'h00;
        end
        mask_chain(MASK_PADDED);
        take_block();
      end
      t.w0 = {chain[0], chain[1]};
      t.w1 = {chain[2], chain[3]};
      t.w2 = {chain[4], chain[5]};
      t.w3 = {chain[6], chain[7]};
      tags_due.push_back(t);
      fill = 0;
      nblocks = 0;
    endfunction

    function void check_tag(logic [63:0] a0, logic [63:0] a1, logic [63:0] a2,
                            logic [63:0] a3);
      tag_exp_t t;
      if (tags_due.size() == 0) begin
        $error("unexpected tag beat %h %h %h %h", a0, a1, a2, a3);
        errors++;
        return;
      end
      t = tags_due.pop_front();
      if (a0 !== t.w0) begin
        $error("tag_word_0 expected %h actual %h", t.w0, a0); errors++;
      end
      if (a1 !== t.w1) begin
        $error("tag_word_1 expected %h actual %h", t.w1, a1); errors++;
      end
      if (a2 !== t.w2) begin
        $error("tag_word_2 expected %h actual %h", t.w2, a2); errors++;
      end
      if (a3 !== t.w3) begin
        $error("tag_word_3 expected %h actual %h", t.w3, a3); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  kscm_msg_if msg_if();
  kscm_tag_if tag_if();

  keyed_sha256_chain_mac_unit dut (
    .clk(clk), .rst(rst), .msg(msg_if), .tag(tag_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tag_scoreboard sb = new();
  int beats_sent = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_key(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(int'(idx) * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.key_reg[int'(idx)] = val;
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    write_key(REG_KEY_0, k0);
    write_key(REG_KEY_1, k1);
    write_key(REG_KEY_2, k2);
    write_key(REG_KEY_3, k3);
  endtask

  task automatic send_beat(logic [63:0] word, logic [3:0] cnt, logic last);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_if.valid <= 1'b1;
    msg_if.message_word <= word;
    msg_if.byte_count <= cnt;
    msg_if.last_item <= last;
    do @(posedge clk); while (!msg_if.ready);
    sb.note_beat(word, cnt, last);
    beats_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // full beats with random content and a last beat with the rest; noisy mode adds short, empty and oversized counts
  task automatic send_message(int nbytes, bit noisy);
    int rem;
    int c;
    int pick;
    rem = nbytes;
    while (rem > 8) begin
      c = 8;
      if (noisy) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) c = 0;
        else if (pick < 3) c = $urandom_range(1, 7);
        else if (pick < 5) c = $urandom_range(9, 15);
      end
      send_beat(rand64(), 4'(c), 1'b0);
      rem -= (c > 8) ? 8 : c;
    end
    c = rem;
    if (noisy && rem == 8 && $urandom_range(0, 3) == 0) c = $urandom_range(9, 15);
    send_beat(rand64(), 4'(c), 1'b1);
  endtask

  // stop offering beats, then wait until every tag is back and the block is idle
  task automatic drain();
    msg_if.valid <= 1'b0;
    while (sb.tags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int stall;
    tag_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        tag_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tag_if.ready <= 1'b1;
      do @(posedge clk); while (!tag_if.valid);
      sb.check_tag(tag_if.tag_word_0, tag_if.tag_word_1, tag_if.tag_word_2,
                   tag_if.tag_word_3);
    end
  end

  initial begin
    int len;
    int pick;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    msg_if.valid = 1'b0;
    msg_if.message_word = '0;
    msg_if.byte_count = '0;
    msg_if.last_item = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key, empty message, extremes of the word
    send_beat(64'h0, 4'd0, 1'b1);
    send_beat(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    send_beat(64'h0, 4'd8, 1'b1);
    send_beat(64'ha5a5_a5a5_a5a5_a5a5, 4'd1, 1'b1);
    send_beat(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
    drain();
    load_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
             64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    // zero-count beat without last, short beat mid-message
    send_beat(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
    send_beat(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0);
    send_beat(64'hfedc_ba98_7654_3210, 4'd5, 1'b1);
    send_message(64, 1'b0);
    drain();
    // two whole blocks: unpadded ending
    send_message(128, 1'b0);
    drain();
    load_key(rand64(), rand64(), rand64(), rand64());
    send_message(56, 1'b0);
    drain();

    while (beats_sent < TARGET_BEATS) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) load_key('0, '0, '0, '0);
      else if (pick == 1)
        load_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      else load_key(rand64(), rand64(), rand64(), rand64());
      repeat (12) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) len = $urandom_range(0, 70);
        else if (pick < 7) len = 64 * $urandom_range(1, 4);
        else len = $urandom_range(0, 300);
        send_message(len, $urandom_range(0, 3) == 0);
      end
      drain();
    end

    if (sb.errors == 0 && sb.tags_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
